// File: sv/cartridge_address_decoder_unit_defines.svh
// Assertion macros shared by the cartridge address decoder.
// They expect clk_i and rst_ni in the scope where they are used.
`ifndef CARTRIDGE_ADDRESS_DECODER_UNIT_DEFINES_SVH
`define CARTRIDGE_ADDRESS_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define CADU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cartridge decoder check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define CADU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cartridge decoder check failed");
`else
`define CADU_ASSERT_IMP(lbl, ante, cons)
`define CADU_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: sv/cadu_pkg.sv
`default_nettype none

package cadu_pkg;

  // Field widths of the bus request, the result and the configuration.
  localparam int unsigned BANK_W     = 8;
  localparam int unsigned OFS_W      = 16;
  localparam int unsigned TGT_W      = 2;
  localparam int unsigned BYTE_OFS_W = 23;
  localparam int unsigned WAIT_W     = 4;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned ROM_W      = 24;
  localparam int unsigned SRAM_W     = 18;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 24;

  // Remainder unit: dividend and divisor widths, one cell per dividend bit.
  localparam int unsigned DIVD_W    = 22;
  localparam int unsigned DIVS_W    = 24;
  localparam int unsigned DIV_STEPS = DIVD_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_MODE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BYTES  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRAM_BYTES = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_ROM   = 4'd3;

  // Cartridge layouts.
  localparam logic [MODE_W-1:0] MODE_LOROM   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HIROM   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EXHIROM = 2'd2;

  // Target codes.
  localparam logic [TGT_W-1:0] TGT_NONE = 2'd0;
  localparam logic [TGT_W-1:0] TGT_ROM  = 2'd1;
  localparam logic [TGT_W-1:0] TGT_SRAM = 2'd2;

  // Access costs in master cycles.
  localparam logic [WAIT_W-1:0] WAIT_NONE = 4'd0;
  localparam logic [WAIT_W-1:0] WAIT_FAST = 4'd6;
  localparam logic [WAIT_W-1:0] WAIT_SLOW = 4'd8;

  // Start of the lower ExHiROM window inside the ROM image.
  localparam logic [ROM_W-1:0] EXHI_BASE = 24'h400000;

  // One request in flight through the decoder.
  typedef struct packed {
    logic [TGT_W-1:0]      target;
    logic [BYTE_OFS_W-1:0] base;
    logic [WAIT_W-1:0]     wait_cycles;
    logic                  use_mod;
    logic                  use_window;
    logic [DIVD_W-1:0]     dividend;
    logic [DIVS_W-1:0]     rem;
  } cadu_item_t;

endpackage

`default_nettype wire

// File: sv/cadu_if.sv
`default_nettype none

// Bus address request channel.
interface cadu_in_if;
  logic                       valid;
  logic                       ready;
  logic [cadu_pkg::BANK_W-1:0] cpu_bank;
  logic [cadu_pkg::OFS_W-1:0]  bank_offset_in;

  modport source (output valid, output cpu_bank, output bank_offset_in, input ready);
  modport sink   (input valid, input cpu_bank, input bank_offset_in, output ready);
endinterface

// Decode result channel.
interface cadu_out_if;
  logic                           valid;
  logic                           ready;
  logic [cadu_pkg::TGT_W-1:0]      target;
  logic [cadu_pkg::BYTE_OFS_W-1:0] byte_offset;
  logic [cadu_pkg::WAIT_W-1:0]     wait_cycles;

  modport source (output valid, output target, output byte_offset, output wait_cycles,
                  input ready);
  modport sink   (input valid, input target, input byte_offset, input wait_cycles,
                  output ready);
endinterface

// Configuration write channel.
interface cadu_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cadu_pkg::CFG_IDX_W-1:0]  index;
  logic [cadu_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/cadu_decode.sv
`default_nettype none

module cadu_decode (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  output logic                                 ready_o,
  input  wire logic [cadu_pkg::BANK_W-1:0]     cpu_bank_i,
  input  wire logic [cadu_pkg::OFS_W-1:0]      bank_offset_in_i,
  input  wire logic [cadu_pkg::MODE_W-1:0]     map_mode_i,
  input  wire logic                            rom_big_i,
  input  wire logic                            sram_on_i,
  input  wire logic                            fast_rom_i,
  output logic                                 valid_o,
  input  wire logic                            ready_i,
  output cadu_pkg::cadu_item_t                 item_o
);

  logic                 valid_q;
  cadu_pkg::cadu_item_t item_q;
  cadu_pkg::cadu_item_t item_d;
  logic [7:0]           page;
  logic [7:0]           low_byte;
  logic [6:0]           bank_lo;
  logic [cadu_pkg::WAIT_W-1:0] cost;
  logic                 lo_sram_bank;
  logic                 hi_sram_win;
  logic                 hi_rom;

  // Window decode: target, fixed part of the offset and what still needs a remainder.
  always_comb begin
    page         = bank_offset_in_i[15:8];
    low_byte     = bank_offset_in_i[7:0];
    bank_lo      = cpu_bank_i[6:0];
    cost         = (cpu_bank_i[7] && fast_rom_i) ? cadu_pkg::WAIT_FAST : cadu_pkg::WAIT_SLOW;
    lo_sram_bank = (cpu_bank_i >= 8'h70 && cpu_bank_i <= 8'h7D) || (cpu_bank_i >= 8'hF0);
    hi_sram_win  = (page[7:5] == 3'b011) && (bank_lo[6:5] == 2'b01);
    hi_rom       = !bank_lo[6] ? page[7] : ((cpu_bank_i >= 8'hC0) || (bank_lo <= 7'h7D));

    item_d             = '0;
    item_d.target      = cadu_pkg::TGT_NONE;
    item_d.wait_cycles = cadu_pkg::WAIT_NONE;

    case (map_mode_i)
      cadu_pkg::MODE_LOROM: begin
        if (page[7] && cpu_bank_i != 8'h7E && cpu_bank_i != 8'h7F) begin
          item_d.target      = cadu_pkg::TGT_ROM;
          item_d.base        = {1'b0, bank_lo, bank_offset_in_i[14:0]};
          item_d.wait_cycles = cost;
        end else if (!page[7] && sram_on_i && lo_sram_bank) begin
          item_d.target      = cadu_pkg::TGT_SRAM;
          item_d.base        = {15'd0, low_byte};
          item_d.use_mod     = 1'b1;
          item_d.dividend    = {6'd0, page, 8'd0};
          item_d.wait_cycles = cadu_pkg::WAIT_SLOW;
        end
      end
      cadu_pkg::MODE_HIROM, cadu_pkg::MODE_EXHIROM: begin
        if (hi_sram_win) begin
          // The SRAM window shadows ROM even when no SRAM is fitted.
          if (sram_on_i) begin
            item_d.target      = cadu_pkg::TGT_SRAM;
            item_d.base        = {15'd0, low_byte};
            item_d.use_mod     = 1'b1;
            item_d.dividend    = {9'd0, page[4:0], 8'd0};
            item_d.wait_cycles = cadu_pkg::WAIT_SLOW;
          end
        end else if (hi_rom) begin
          if (map_mode_i == cadu_pkg::MODE_HIROM || cpu_bank_i[7]) begin
            item_d.target      = cadu_pkg::TGT_ROM;
            item_d.base        = {1'b0, cpu_bank_i[5:0], bank_offset_in_i};
            item_d.wait_cycles = cost;
          end else if (rom_big_i) begin
            // Lower ExHiROM banks mirror the part of the ROM above 4 MiB.
            item_d.target      = cadu_pkg::TGT_ROM;
            item_d.base        = {1'b1, 14'd0, low_byte};
            item_d.use_mod     = 1'b1;
            item_d.use_window  = 1'b1;
            item_d.dividend    = {cpu_bank_i[5:0], page, 8'd0};
            item_d.wait_cycles = cadu_pkg::WAIT_SLOW;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Stage register: loads whenever it is empty or its neighbor takes its content.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// File: sv/cadu_mod_cell.sv
`default_nettype none

module cadu_mod_cell (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             valid_i,
  output logic                                  ready_o,
  input  wire cadu_pkg::cadu_item_t             item_i,
  input  wire logic [cadu_pkg::SRAM_W-1:0]      sram_bytes_i,
  input  wire logic [cadu_pkg::DIVS_W-1:0]      window_i,
  output logic                                  valid_o,
  input  wire logic                             ready_i,
  output cadu_pkg::cadu_item_t                  item_o
);

  logic                        valid_q;
  cadu_pkg::cadu_item_t        item_q;
  cadu_pkg::cadu_item_t        item_d;
  logic [cadu_pkg::DIVS_W-1:0] divisor;
  logic [cadu_pkg::DIVS_W:0]   partial;
  logic [cadu_pkg::DIVS_W:0]   diff;

  // One restoring remainder step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    divisor = item_i.use_window ? window_i
                                : {{(cadu_pkg::DIVS_W-cadu_pkg::SRAM_W){1'b0}}, sram_bytes_i};
    partial = {item_i.rem, item_i.dividend[cadu_pkg::DIVD_W-1]};
    diff    = partial - {1'b0, divisor};
    item_d  = item_i;
    item_d.rem      = (partial >= {1'b0, divisor}) ? diff[cadu_pkg::DIVS_W-1:0]
                                                   : partial[cadu_pkg::DIVS_W-1:0];
    item_d.dividend = {item_i.dividend[cadu_pkg::DIVD_W-2:0], 1'b0};
  end

  // Hand-off register to the next cell.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// File: sv/cartridge_address_decoder_unit.sv
// Cartridge address decoder.
// A request on in_i carries one CPU bus address as cpu_bank and bank_offset_in.
// Each request yields exactly one result on out_o: target (none, ROM, SRAM),
// byte_offset inside that store and wait_cycles in master cycles, in request order.
// cfg_i writes map_mode, rom_bytes, sram_bytes and fast_rom by index 0 to 3;
// cfg_i.ready is always high, and writes are meant for an idle decoder.
// Each request passes one decode register, 22 remainder cells and the output
// register on its way to the result. The remainder cells, one per dividend bit,
// serve the SRAM page wrap and the ExHiROM mirror window.
// Throughput is one request per cycle while out_o is not stalled. Every stage
// has its own valid bit, so bubbles close up and a request is taken while a
// result waits on out_o. When the receiver stalls, the result holds and the
// stages fill behind it; in_i.ready drops only once every stage is full.
// Reset clears all stages and sets the configuration as if each register held
// zero (LoROM, no SRAM, slow ROM); results reach out_o only for accepted requests.
`default_nettype none
`include "cartridge_address_decoder_unit_defines.svh"

module cartridge_address_decoder_unit (
  input wire logic clk_i,
  input wire logic rst_ni,
  cadu_in_if.sink    in_i,
  cadu_out_if.source out_o,
  cadu_cfg_if.sink   cfg_i
);

  logic [cadu_pkg::MODE_W-1:0] map_mode_q;
  logic [cadu_pkg::DIVS_W-1:0] window_q;
  logic                        rom_big_q;
  logic [cadu_pkg::SRAM_W-1:0] sram_bytes_q;
  logic                        fast_rom_q;

  logic [cadu_pkg::DIV_STEPS:0] chain_valid;
  logic [cadu_pkg::DIV_STEPS:0] chain_ready;
  cadu_pkg::cadu_item_t         chain_item [cadu_pkg::DIV_STEPS+1];
  cadu_pkg::cadu_item_t         last_item;

  logic                            out_v_q;
  logic [cadu_pkg::TGT_W-1:0]      target_q;
  logic [cadu_pkg::BYTE_OFS_W-1:0] byte_offset_q;
  logic [cadu_pkg::WAIT_W-1:0]     wait_q;
  logic                            out_take;
  logic [cadu_pkg::BYTE_OFS_W-1:0] rem_add;

  // Configuration registers; the ExHiROM window is kept precomputed.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_mode_q   <= cadu_pkg::MODE_LOROM;
      window_q     <= '0 - cadu_pkg::EXHI_BASE;
      rom_big_q    <= 1'b0;
      sram_bytes_q <= '0;
      fast_rom_q   <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        cadu_pkg::CFG_MAP_MODE: begin
          map_mode_q <= cfg_i.data[cadu_pkg::MODE_W-1:0];
        end
        cadu_pkg::CFG_ROM_BYTES: begin
          window_q  <= cfg_i.data[cadu_pkg::ROM_W-1:0] - cadu_pkg::EXHI_BASE;
          rom_big_q <= cfg_i.data[cadu_pkg::ROM_W-1:0] > cadu_pkg::EXHI_BASE;
        end
        cadu_pkg::CFG_SRAM_BYTES: begin
          sram_bytes_q <= cfg_i.data[cadu_pkg::SRAM_W-1:0];
        end
        cadu_pkg::CFG_FAST_ROM: begin
          fast_rom_q <= cfg_i.data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Front cell: window decode.
  cadu_decode u_decode (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (in_i.valid),
    .ready_o          (in_i.ready),
    .cpu_bank_i       (in_i.cpu_bank),
    .bank_offset_in_i (in_i.bank_offset_in),
    .map_mode_i       (map_mode_q),
    .rom_big_i        (rom_big_q),
    .sram_on_i        (sram_bytes_q != '0),
    .fast_rom_i       (fast_rom_q),
    .valid_o          (chain_valid[0]),
    .ready_i          (chain_ready[0]),
    .item_o           (chain_item[0])
  );

  // Row of remainder cells, one dividend bit each.
  for (genvar k = 0; k < cadu_pkg::DIV_STEPS; k++) begin : g_cell
    cadu_mod_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .valid_i      (chain_valid[k]),
      .ready_o      (chain_ready[k]),
      .item_i       (chain_item[k]),
      .sram_bytes_i (sram_bytes_q),
      .window_i     (window_q),
      .valid_o      (chain_valid[k+1]),
      .ready_i      (chain_ready[k+1]),
      .item_o       (chain_item[k+1])
    );
  end

  // Output register: adds the remainder to the fixed part of the offset.
  assign last_item = chain_item[cadu_pkg::DIV_STEPS];
  assign out_take  = !out_v_q || out_o.ready;
  assign chain_ready[cadu_pkg::DIV_STEPS] = out_take;
  assign rem_add   = last_item.use_mod ? last_item.rem[cadu_pkg::BYTE_OFS_W-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_take) begin
      out_v_q <= chain_valid[cadu_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && chain_valid[cadu_pkg::DIV_STEPS]) begin
      target_q      <= last_item.target;
      byte_offset_q <= last_item.base + rem_add;
      wait_q        <= last_item.wait_cycles;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.target      = target_q;
  assign out_o.byte_offset = byte_offset_q;
  assign out_o.wait_cycles = wait_q;

  // An unmapped result carries no offset and no cost.
  `CADU_ASSERT_IMP(a_unmapped_zero, out_v_q && target_q == cadu_pkg::TGT_NONE, byte_offset_q == '0 && wait_q == cadu_pkg::WAIT_NONE)
  // A mapped result always costs WAIT_FAST or WAIT_SLOW master cycles.
  `CADU_ASSERT_IMP(a_mapped_cost, out_v_q && target_q != cadu_pkg::TGT_NONE, wait_q == cadu_pkg::WAIT_FAST || wait_q == cadu_pkg::WAIT_SLOW)
  // An accepted request lands in the decode register.
  `CADU_ASSERT_NXT(a_accept_loads, in_i.valid && in_i.ready, chain_valid[0])

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cadu_pkg::*;

  // The fourth layout code maps nothing.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned CHUNKS       = 9;
  localparam int unsigned CHUNK_REQS   = 70;
  localparam int unsigned DIR_ROWS_N   = 25;

  // One decode result as it leaves the block.
  typedef struct packed {
    logic [TGT_W-1:0]      target;
    logic [BYTE_OFS_W-1:0] byte_offset;
    logic [WAIT_W-1:0]     wait_cycles;
  } decode_t;

  // One directed request with the configuration it runs under.
  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [ROM_W-1:0]      rom;
    logic [SRAM_W-1:0]     sram;
    logic                  fast;
    logic [BANK_W-1:0]     bank;
    logic [OFS_W-1:0]      ofs;
    logic                  typed;
    logic [TGT_W-1:0]      want_tgt;
    logic [BYTE_OFS_W-1:0] want_ofs;
    logic [WAIT_W-1:0]     want_wait;
  } dir_row_t;

  // Directed requests: fixed results only where they are obvious.
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    // Reset configuration: LoROM, no SRAM, slow ROM.
    '{MODE_LOROM, 24'h0, 18'h0, 1'b0, 8'h00, 16'h0000, 1'b1, TGT_NONE, 23'h0, WAIT_NONE},
    '{MODE_LOROM, 24'h0, 18'h0, 1'b0, 8'h00, 16'h8000, 1'b1, TGT_ROM, 23'h0, WAIT_SLOW},
    '{MODE_LOROM, 24'h0, 18'h0, 1'b0, 8'hFF, 16'hFFFF, 1'b1, TGT_ROM, 23'h3FFFFF, WAIT_SLOW},
    '{MODE_LOROM, 24'h0, 18'h0, 1'b0, 8'h7E, 16'h8000, 1'b1, TGT_NONE, 23'h0, WAIT_NONE},
    '{MODE_LOROM, 24'h0, 18'h0, 1'b0, 8'h70, 16'h0000, 1'b1, TGT_NONE, 23'h0, WAIT_NONE},
    // LoROM with 2 KiB SRAM and fast ROM.
    '{MODE_LOROM, 24'h0, 18'h800, 1'b1, 8'h70, 16'h1234, 1'b1, TGT_SRAM, 23'h234, WAIT_SLOW},
    '{MODE_LOROM, 24'h0, 18'h800, 1'b1, 8'hFF, 16'h7FFF, 1'b1, TGT_SRAM, 23'h7FF, WAIT_SLOW},
    '{MODE_LOROM, 24'h0, 18'h800, 1'b1, 8'h80, 16'h8000, 1'b1, TGT_ROM, 23'h0, WAIT_FAST},
    '{MODE_LOROM, 24'h0, 18'h800, 1'b1, 8'h7D, 16'h8000, 1'b0, TGT_NONE, 23'h0, WAIT_NONE},
    '{MODE_LOROM, 24'h0, 18'h800, 1'b1, 8'h6F, 16'h0000, 1'b1, TGT_NONE, 23'h0, WAIT_NONE},
    // HiROM with 8 KiB SRAM and fast ROM.
    '{MODE_HIROM, 24'h400000, 18'h2000, 1'b1, 8'h00, 16'h7FFF, 1'b1, TGT_NONE, 23'h0,
      WAIT_NONE},
    '{MODE_HIROM, 24'h400000, 18'h2000, 1'b1, 8'h20, 16'h6000, 1'b1, TGT_SRAM, 23'h0,
      WAIT_SLOW},
    '{MODE_HIROM, 24'h400000, 18'h2000, 1'b1, 8'hC0, 16'h0000, 1'b1, TGT_ROM, 23'h0,
      WAIT_FAST},
    '{MODE_HIROM, 24'h400000, 18'h2000, 1'b1, 8'hFF, 16'hFFFF, 1'b1, TGT_ROM, 23'h3FFFFF,
      WAIT_FAST},
    '{MODE_HIROM, 24'h400000, 18'h2000, 1'b1, 8'h7E, 16'h0000, 1'b1, TGT_NONE, 23'h0,
      WAIT_NONE},
    '{MODE_HIROM, 24'h400000, 18'h2000, 1'b1, 8'h40, 16'h1234, 1'b0, TGT_NONE, 23'h0,
      WAIT_NONE},
    // ExHiROM with a 6 MiB image: lower banks mirror a 2 MiB window.
    '{MODE_EXHIROM, 24'h600000, 18'h2000, 1'b0, 8'h00, 16'h8000, 1'b0, TGT_NONE, 23'h0,
      WAIT_NONE},
    '{MODE_EXHIROM, 24'h600000, 18'h2000, 1'b0, 8'h7D, 16'hFFFF, 1'b0, TGT_NONE, 23'h0,
      WAIT_NONE},
    '{MODE_EXHIROM, 24'h600000, 18'h2000, 1'b0, 8'h80, 16'h8000, 1'b1, TGT_ROM, 23'h8000,
      WAIT_SLOW},
    // ExHiROM with a 4 MiB image leaves the lower banks unmapped.
    '{MODE_EXHIROM, 24'h400000, 18'h2000, 1'b0, 8'h40, 16'h0000, 1'b1, TGT_NONE, 23'h0,
      WAIT_NONE},
    // Register maxima, SRAM size not a whole number of pages.
    '{MODE_EXHIROM, 24'hFFFFFF, 18'h3FFFF, 1'b1, 8'h3F, 16'hFFFF, 1'b0, TGT_NONE, 23'h0,
      WAIT_NONE},
    '{MODE_EXHIROM, 24'hFFFFFF, 18'h3FFFF, 1'b1, 8'hA0, 16'h7F80, 1'b0, TGT_NONE, 23'h0,
      WAIT_NONE},
    // Unused layout code maps nothing at all.
    '{MODE_UNUSED, 24'hFFFFFF, 18'h123, 1'b1, 8'h80, 16'h8000, 1'b1, TGT_NONE, 23'h0,
      WAIT_NONE},
    '{MODE_UNUSED, 24'hFFFFFF, 18'h123, 1'b1, 8'h70, 16'h0000, 1'b1, TGT_NONE, 23'h0,
      WAIT_NONE},
    // Odd SRAM size back in LoROM.
    '{MODE_LOROM, 24'h0, 18'h123, 1'b0, 8'hF0, 16'h7FFF, 1'b0, TGT_NONE, 23'h0, WAIT_NONE}
  };

  // Banks and pages at the edges of the mapping windows.
  localparam logic [7:0] BANK_EDGES [18] = '{
    8'h00, 8'h1F, 8'h20, 8'h3F, 8'h40, 8'h6F, 8'h70, 8'h7D, 8'h7E,
    8'h7F, 8'h80, 8'h9F, 8'hA0, 8'hBF, 8'hC0, 8'hEF, 8'hF0, 8'hFF
  };
  localparam logic [7:0] PAGE_EDGES [8] = '{
    8'h00, 8'h5F, 8'h60, 8'h61, 8'h7F, 8'h80, 8'hC0, 8'hFF
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cadu_in_if  req_if ();
  cadu_out_if res_if ();
  cadu_cfg_if cfg_if ();

  cartridge_address_decoder_unit u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (req_if),
    .out_o (res_if),
    .cfg_i (cfg_if)
  );

  // Shadow copy of the decoder configuration.
  logic [MODE_W-1:0] cur_mode = MODE_LOROM;
  logic [ROM_W-1:0]  cur_rom  = '0;
  logic [SRAM_W-1:0] cur_sram = '0;
  logic              cur_fast = 1'b0;

  decode_t     pending_decodes[$];
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  int unsigned hold_cycles  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decode one bus address under the shadow configuration.
  function automatic decode_t decode_address(input logic [BANK_W-1:0] bank,
                                             input logic [OFS_W-1:0] ofs);
    decode_t     r;
    logic [31:0] page;
    logic [31:0] lo;
    logic [31:0] b;
    logic [31:0] off;
    logic [31:0] window;
    logic [31:0] ideal;
    logic        hi_page;
    logic [WAIT_W-1:0] rom_cost;
    r = '{TGT_NONE, '0, WAIT_NONE};
    off = '0;
    page = {24'h0, ofs[15:8]};
    lo = {24'h0, ofs[7:0]};
    b = {24'h0, bank & 8'h7F};
    rom_cost = (bank[7] && cur_fast) ? WAIT_FAST : WAIT_SLOW;
    case (cur_mode)
      MODE_LOROM: begin
        if (page >= 32'h80 && bank != 8'h7E && bank != 8'h7F) begin
          r.target = TGT_ROM;
          off = b * 32'h8000 + ({16'h0, ofs} - 32'h8000);
          r.wait_cycles = rom_cost;
        end else if (page < 32'h80 && cur_sram != 0 &&
                     ((bank >= 8'h70 && bank <= 8'h7D) || bank >= 8'hF0)) begin
          r.target = TGT_SRAM;
          off = (page * 32'h100) % cur_sram + lo;
          r.wait_cycles = WAIT_SLOW;
        end
      end
      MODE_HIROM, MODE_EXHIROM: begin
        if (page >= 32'h60 && page <= 32'h7F && b >= 32'h20 && b <= 32'h3F) begin
          // SRAM pages in the middle banks; only mapped when SRAM exists.
          if (cur_sram != 0) begin
            r.target = TGT_SRAM;
            off = ((page - 32'h60) * 32'h100) % cur_sram + lo;
            r.wait_cycles = WAIT_SLOW;
          end
        end else begin
          if (b <= 32'h3F) begin
            hi_page = (page >= 32'h80);
          end else if (bank >= 8'hC0) begin
            hi_page = 1'b1;
          end else begin
            hi_page = (b <= 32'h7D);
          end
          if (hi_page) begin
            if (cur_mode == MODE_HIROM || bank[7]) begin
              r.target = TGT_ROM;
              off = ((b & 32'h3F) << 16) | {16'h0, ofs};
              r.wait_cycles = rom_cost;
            end else if (cur_rom > EXHI_BASE) begin
              // Lower ExHiROM banks wrap within the image above 4 MiB.
              window = cur_rom - EXHI_BASE;
              ideal = ((b & 32'h3F) << 16) + page * 32'h100;
              r.target = TGT_ROM;
              off = 32'h400000 + ideal % window + lo;
              r.wait_cycles = WAIT_SLOW;
            end
          end
        end
      end
      default: begin
      end
    endcase
    r.byte_offset = off[BYTE_OFS_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    if (fail_count < 40) begin
      $display("mismatch on %s at cycle %0d: expected %0h, got %0h",
               field, cycle_count, want, got);
    end
    fail_count++;
  endtask

  // Offer one request, then record what it should decode to once it is taken.
  task automatic send_request(input logic [BANK_W-1:0] bank, input logic [OFS_W-1:0] ofs,
                              input logic typed, input decode_t want);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.cpu_bank <= bank;
    req_if.bank_offset_in <= ofs;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_decodes.push_back(typed ? want : decode_address(bank, ofs));
  endtask

  // Stop offering requests until every result is back.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_MAP_MODE:   cur_mode = data[MODE_W-1:0];
      CFG_ROM_BYTES:  cur_rom = data[ROM_W-1:0];
      CFG_SRAM_BYTES: cur_sram = data[SRAM_W-1:0];
      CFG_FAST_ROM:   cur_fast = data[0];
      default: begin
      end
    endcase
  endtask

  // Reconfigure an idle decoder: all four registers in one burst.
  task automatic apply_config(input logic [MODE_W-1:0] mode, input logic [ROM_W-1:0] rom,
                              input logic [SRAM_W-1:0] sram, input logic fast);
    wait_drained();
    write_reg(CFG_MAP_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_ROM_BYTES, CFG_DATA_W'(rom));
    write_reg(CFG_SRAM_BYTES, CFG_DATA_W'(sram));
    write_reg(CFG_FAST_ROM, CFG_DATA_W'(fast));
    cfg_if.valid <= 1'b0;
  endtask

  // Known values on every block input from the start.
  initial begin
    req_if.valid <= 1'b0;
    req_if.cpu_bank <= '0;
    req_if.bank_offset_in <= '0;
    res_if.ready <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
  end

  // Result receiver: random stalls, or a long hold-off when one is requested.
  initial begin : drive_ready
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        res_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  // Compare every result taken with the oldest pending decode.
  always @(posedge clk) begin : check_results
    decode_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_decodes.size() == 0) begin
        report_mismatch("unexpected result", 0, res_if.target);
      end else begin
        want = pending_decodes.pop_front();
        if (res_if.target !== want.target) begin
          report_mismatch("target", want.target, res_if.target);
        end
        if (res_if.byte_offset !== want.byte_offset) begin
          report_mismatch("byte_offset", want.byte_offset, res_if.byte_offset);
        end
        if (res_if.wait_cycles !== want.wait_cycles) begin
          report_mismatch("wait_cycles", want.wait_cycles, res_if.wait_cycles);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t          row;
    logic [MODE_W-1:0] mode;
    logic [ROM_W-1:0]  rom;
    logic [SRAM_W-1:0] sram;
    logic [BANK_W-1:0] bank;
    logic [7:0]        page;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests, reconfiguring only where a row asks for it.
    for (int i = 0; i < DIR_ROWS_N; i++) begin
      row = DIR_ROWS[i];
      if (row.mode != cur_mode || row.rom != cur_rom || row.sram != cur_sram ||
          row.fast != cur_fast) begin
        apply_config(row.mode, row.rom, row.sram, row.fast);
      end
      send_request(row.bank, row.ofs, row.typed,
                   '{row.want_tgt, row.want_ofs, row.want_wait});
    end

    // Random requests in three idling phases, new configuration per chunk.
    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 80 : 0;
      out_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 21 : 0;
      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
        mode = ($urandom_range(0, 7) == 0) ? MODE_UNUSED : MODE_W'($urandom_range(0, 2));
        case ($urandom_range(0, 4))
          0: rom = '0;
          1: rom = EXHI_BASE;
          2: rom = ROM_W'($urandom_range(24'h400001, 24'h800000));
          3: rom = 24'hFFFFFF;
          default: rom = ROM_W'($urandom_range(0, 24'hFFFFFF));
        endcase
        case ($urandom_range(0, 3))
          0: sram = '0;
          1: sram = 18'h400 << $urandom_range(0, 7);
          2: sram = SRAM_W'($urandom_range(1, 18'h3FFFF));
          default: sram = 18'h3FFFF;
        endcase
        apply_config(mode, rom, sram, 1'(($urandom_range(0, 1))));
        // Long receiver stall at the start of each phase fills the pipeline.
        if (chunk == 0) begin
          hold_cycles = HOLD_CYCLES;
        end
        repeat (CHUNK_REQS) begin
          bank = ($urandom_range(0, 2) == 0) ? BANK_W'($urandom_range(0, 255))
                                              : BANK_EDGES[$urandom_range(0, 17)];
          page = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                              : PAGE_EDGES[$urandom_range(0, 7)];
          send_request(bank, {page, 8'($urandom_range(0, 255))}, 1'b0, '0);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+sv
sv/cadu_pkg.sv
sv/cadu_if.sv
sv/cadu_decode.sv
sv/cadu_mod_cell.sv
sv/cartridge_address_decoder_unit.sv
tb/sv/tb.sv
